// ----- sv/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
// No dependencies; imported by spq_cell and stable_priority_queue.
package spq_pkg;

    localparam int VALUE_W        = 32;
    localparam int PRIO_IN_W      = 16;
    localparam int DEPTH_DEF      = 16;
    localparam int PRIO_WIDTH_DEF = 16;

    // Result status codes
    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Per-cycle operation broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } ctl_t;

endpackage

// ----- sv/spq_cell.sv -----
// One slot of the sorted cell row: holds a value and its priority.
// Depends on spq_pkg (ctl_t, VALUE_W).
module spq_cell #(
    parameter int PRIO_W = 16
) (
    input  logic                                  clk,
    input  spq_pkg::ctl_t                         ctl,
    input  logic                                  occupied,
    input  logic signed [spq_pkg::VALUE_W-1:0]    new_value,
    input  logic        [PRIO_W-1:0]              new_prio,
    input  logic                                  left_keep,
    input  logic signed [spq_pkg::VALUE_W-1:0]    left_value,
    input  logic        [PRIO_W-1:0]              left_prio,
    input  logic signed [spq_pkg::VALUE_W-1:0]    right_value,
    input  logic        [PRIO_W-1:0]              right_prio,
    output logic signed [spq_pkg::VALUE_W-1:0]    value,
    output logic        [PRIO_W-1:0]              prio,
    output logic                                  keep
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic        [PRIO_W-1:0]  prio_reg;
    logic        [PRIO_W-1:0]  prio_next;

    // Hold the entry when it is served no later than the new one
    assign keep = occupied && (prio_reg <= new_prio);

    // Choose: hold, take the new entry, shift from left, or shift from right
    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctl.enq)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    value_next = new_value;
                    prio_next  = new_prio;
                end
                else
                begin
                    value_next = left_value;
                    prio_next  = left_prio;
                end
            end
        end
        else if (ctl.deq)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

// ----- sv/stable_priority_queue.sv -----
// Stable sorted priority queue built from a row of slot cells.
// The result of an item is registered and presented in the cycle after its transfer.
// Throughput: one item per cycle while the result is drained (out_ready); every cell compares and shifts in parallel.
// Reset clears the entry count and the output valid; slot contents stay undefined.
// Depends on spq_pkg and spq_cell.
module stable_priority_queue #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    command,
    input  logic signed [spq_pkg::VALUE_W-1:0]      item_value,
    input  logic        [spq_pkg::PRIO_IN_W-1:0]    item_priority,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output spq_pkg::status_t                        status,
    output logic signed [spq_pkg::VALUE_W-1:0]      out_value,
    output logic        [spq_pkg::PRIO_IN_W-1:0]    out_priority,
    output logic        [CNT_W-1:0]                 occupancy
);
    import spq_pkg::*;

    localparam int PW = (PRIO_WIDTH < PRIO_IN_W) ? PRIO_WIDTH : PRIO_IN_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic signed [VALUE_W-1:0]   value_reg;
    logic signed [VALUE_W-1:0]   value_next;
    logic        [PRIO_IN_W-1:0] prio_reg;
    logic        [PRIO_IN_W-1:0] prio_next;

    logic             xfer;
    logic             full;
    logic             empty;
    ctl_t             ctl;
    logic [PW-1:0]    new_prio;

    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic        [PW-1:0]      cell_prio  [DEPTH];
    logic                      cell_keep  [DEPTH];

    // Accept while the output stage is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign xfer     = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign new_prio = item_priority[PW-1:0];

    assign ctl.enq = xfer && !command && !full;
    assign ctl.deq = xfer && command && !empty;

    // Build the row of cells
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                      l_keep;
            logic signed [VALUE_W-1:0] l_value;
            logic        [PW-1:0]      l_prio;
            logic signed [VALUE_W-1:0] r_value;
            logic        [PW-1:0]      r_prio;

            if (i == 0)
            begin : g_head
                assign l_keep  = 1'b1;
                assign l_value = item_value;
                assign l_prio  = new_prio;
            end
            else
            begin : g_body
                assign l_keep  = cell_keep[i-1];
                assign l_value = cell_value[i-1];
                assign l_prio  = cell_prio[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign r_value = cell_value[i];
                assign r_prio  = cell_prio[i];
            end
            else
            begin : g_mid
                assign r_value = cell_value[i+1];
                assign r_prio  = cell_prio[i+1];
            end

            spq_cell #(
                .PRIO_W (PW)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (CNT_W'(i) < count_reg),
                .new_value   (item_value),
                .new_prio    (new_prio),
                .left_keep   (l_keep),
                .left_value  (l_value),
                .left_prio   (l_prio),
                .right_value (r_value),
                .right_prio  (r_prio),
                .value       (cell_value[i]),
                .prio        (cell_prio[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    // Update the count and form the result
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        prio_next      = prio_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (xfer)
        begin
            out_valid_next = 1'b1;
            value_next     = '0;
            prio_next      = '0;
            if (!command)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_ENQ;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_DEQ;
                    value_next  = cell_value[0];
                    prio_next   = PRIO_IN_W'(cell_prio[0]);
                    count_next  = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        prio_reg   <= prio_next;
    end

    logic [CNT_W-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            occ_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_value    = value_reg;
    assign out_priority = prio_reg;
    assign occupancy    = occ_reg;

endmodule
